FILE: rtl/integer_stack_expression_unit_defines.svh
// ----------------------------------------------------------------------------
// integer_stack_expression_unit_defines
// assertion macros used by the top rtl file of the stack expression unit
// ----------------------------------------------------------------------------
`ifndef INTEGER_STACK_EXPRESSION_UNIT_DEFINES_SVH
`define INTEGER_STACK_EXPRESSION_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define ISU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define ISU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg
// types, constants and decode helpers for the integer stack expression unit
// ----------------------------------------------------------------------------
package isu_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int NUM_VARS    = 32;
    localparam int DATA_W      = 64;
    localparam int VIDX_W      = 5;
    localparam int TAG_W       = VIDX_W + 1;
    localparam int ENTRY_W     = TAG_W + DATA_W;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int VAR_AW      = $clog2(NUM_VARS);
    localparam int OUT_DEPTH_W = 8;

    localparam logic [TAG_W-1:0] NO_TAG = {1'b1, {VIDX_W{1'b0}}};

    typedef enum logic [5:0] {
        CMD_PUSH_LIT = 6'd0,
        CMD_PUSH_VAR = 6'd1,
        CMD_CLEAR    = 6'd2,
        OP_LNOT      = 6'd3,
        OP_BNOT      = 6'd4,
        OP_POSTINC   = 6'd5,
        OP_POSTDEC   = 6'd6,
        OP_PLUS      = 6'd7,
        OP_NEG       = 6'd8,
        OP_AND       = 6'd9,
        OP_XOR       = 6'd10,
        OP_OR        = 6'd11,
        OP_MUL       = 6'd12,
        OP_DIV       = 6'd13,
        OP_MOD       = 6'd14,
        OP_ADD       = 6'd15,
        OP_SUB       = 6'd16,
        OP_SHL       = 6'd17,
        OP_SHR       = 6'd18,
        OP_LT        = 6'd19,
        OP_LE        = 6'd20,
        OP_GT        = 6'd21,
        OP_GE        = 6'd22,
        OP_EQ        = 6'd23,
        OP_NE        = 6'd24,
        OP_LAND      = 6'd25,
        OP_LOR       = 6'd26,
        OP_LXOR      = 6'd27,
        OP_COND      = 6'd28,
        OP_COLON     = 6'd29,
        OP_ASSIGN    = 6'd30,
        OP_ADD_ASN   = 6'd31,
        OP_SUB_ASN   = 6'd32,
        OP_MUL_ASN   = 6'd33,
        OP_DIV_ASN   = 6'd34,
        OP_MOD_ASN   = 6'd35,
        OP_AND_ASN   = 6'd36,
        OP_XOR_ASN   = 6'd37,
        OP_OR_ASN    = 6'd38,
        OP_SHL_ASN   = 6'd39,
        OP_SHR_ASN   = 6'd40,
        OP_LAND_ASN  = 6'd41,
        OP_LOR_ASN   = 6'd42,
        OP_LXOR_ASN  = 6'd43,
        OP_COMMA     = 6'd44,
        OP_PREINC    = 6'd45,
        OP_PREDEC    = 6'd46
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_OVERFLOW = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_DIV_ZERO = 3'd3,
        ERR_LVALUE   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        MD_MUL = 2'd0,
        MD_DIV = 2'd1,
        MD_REM = 2'd2
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } md_rsp_t;

    typedef struct packed {
        logic              en;
        logic [VAR_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } var_wr_t;

    function automatic logic [1:0] operands_needed(cmd_t c);
        logic [1:0] n;
        case (c) inside
            OP_LNOT, OP_BNOT, OP_POSTINC, OP_POSTDEC, OP_PLUS, OP_NEG,
            OP_PREINC, OP_PREDEC: n = 2'd1;
            OP_COND:              n = 2'd3;
            OP_COLON:             n = 2'd0;
            default:              n = 2'd2;
        endcase
        return n;
    endfunction

    // compound assignments map onto their plain binary operator
    function automatic cmd_t base_op(cmd_t c);
        cmd_t b;
        case (c) inside
            OP_ADD_ASN:  b = OP_ADD;
            OP_SUB_ASN:  b = OP_SUB;
            OP_MUL_ASN:  b = OP_MUL;
            OP_DIV_ASN:  b = OP_DIV;
            OP_MOD_ASN:  b = OP_MOD;
            OP_AND_ASN:  b = OP_AND;
            OP_XOR_ASN:  b = OP_XOR;
            OP_OR_ASN:   b = OP_OR;
            OP_SHL_ASN:  b = OP_SHL;
            OP_SHR_ASN:  b = OP_SHR;
            OP_LAND_ASN: b = OP_LAND;
            OP_LOR_ASN:  b = OP_LOR;
            OP_LXOR_ASN: b = OP_LXOR;
            OP_AND, OP_XOR, OP_OR, OP_MUL, OP_DIV, OP_MOD, OP_ADD, OP_SUB,
            OP_SHL, OP_SHR, OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ, OP_NE,
            OP_LAND, OP_LOR, OP_LXOR: b = c;
            default:     b = OP_ASSIGN;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/isu_muldiv.sv
// ----------------------------------------------------------------------------
// isu_muldiv
// multi-cycle 64-bit multiplier (three 32x32 partial products) and
// restoring signed divider (one quotient bit per cycle)
// ----------------------------------------------------------------------------
module isu_muldiv
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  isu_pkg::md_req_t             req,
    input  logic [isu_pkg::DATA_W-1:0]   opa,
    input  logic [isu_pkg::DATA_W-1:0]   opb,
    output isu_pkg::md_rsp_t             rsp
);

    typedef enum logic [2:0] {
        MS_IDLE = 3'b001,
        MS_MUL  = 3'b010,
        MS_DIV  = 3'b100
    } md_state_t;

    md_state_t                    state_reg;
    isu_pkg::md_op_t              op_reg;
    logic [isu_pkg::DATA_W-1:0]   a_reg;
    logic [isu_pkg::DATA_W-1:0]   b_reg;
    logic [isu_pkg::DATA_W-1:0]   acc_reg;
    logic [isu_pkg::DATA_W-1:0]   quot_reg;
    logic [isu_pkg::DATA_W-1:0]   rem_reg;
    logic [5:0]                   cnt_reg;
    logic                         neg_q_reg;
    logic                         neg_r_reg;
    logic                         done_reg;
    logic [isu_pkg::DATA_W-1:0]   result_reg;

    logic [31:0]                  mx;
    logic [31:0]                  my;
    logic [63:0]                  prod;
    logic [isu_pkg::DATA_W-1:0]   acc_next;
    logic [isu_pkg::DATA_W:0]     r2;
    logic [isu_pkg::DATA_W:0]     diff;
    logic                         ge;
    logic [isu_pkg::DATA_W-1:0]   quot_next;
    logic [isu_pkg::DATA_W-1:0]   rem_next;
    logic [isu_pkg::DATA_W-1:0]   ua;
    logic [isu_pkg::DATA_W-1:0]   ub;

    assign ua = opa[isu_pkg::DATA_W-1] ? (~opa + 1'b1) : opa;
    assign ub = opb[isu_pkg::DATA_W-1] ? (~opb + 1'b1) : opb;

    // low 64 bits only: al*bl + ((al*bh + ah*bl) << 32)
    always_comb
    begin
        mx = (cnt_reg == 6'd2) ? a_reg[63:32] : a_reg[31:0];
        my = (cnt_reg == 6'd1) ? b_reg[63:32] : b_reg[31:0];
        prod = {32'b0, mx} * {32'b0, my};
        if (cnt_reg == 6'd0)
        begin
            acc_next = prod;
        end
        else
        begin
            acc_next = acc_reg + {prod[31:0], 32'b0};
        end
    end

    always_comb
    begin
        r2        = {rem_reg, quot_reg[isu_pkg::DATA_W-1]};
        diff      = r2 - {1'b0, b_reg};
        ge        = (r2 >= {1'b0, b_reg});
        rem_next  = ge ? diff[isu_pkg::DATA_W-1:0] : r2[isu_pkg::DATA_W-1:0];
        quot_next = {quot_reg[isu_pkg::DATA_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MS_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= (req.op == isu_pkg::MD_MUL) ? MS_MUL : MS_DIV;
                    end
                end
                MS_MUL:
                begin
                    if (cnt_reg == 6'd2)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= MS_IDLE;
                    end
                end
                MS_DIV:
                begin
                    if (cnt_reg == 6'd63)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= MS_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= MS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MS_IDLE && req.start)
        begin
            op_reg    <= req.op;
            cnt_reg   <= 6'd0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            neg_q_reg <= opa[isu_pkg::DATA_W-1] ^ opb[isu_pkg::DATA_W-1];
            neg_r_reg <= opa[isu_pkg::DATA_W-1];
            if (req.op == isu_pkg::MD_MUL)
            begin
                a_reg <= opa;
                b_reg <= opb;
            end
            else
            begin
                b_reg    <= ub;
                quot_reg <= ua;
            end
        end
        else if (state_reg == MS_MUL)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd2)
            begin
                result_reg <= acc_next;
            end
        end
        else if (state_reg == MS_DIV)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                if (op_reg == isu_pkg::MD_DIV)
                begin
                    result_reg <= neg_q_reg ? (~quot_next + 1'b1) : quot_next;
                end
                else
                begin
                    result_reg <= neg_r_reg ? (~rem_next + 1'b1) : rem_next;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

FILE: rtl/isu_var_store.sv
// ----------------------------------------------------------------------------
// isu_var_store
// variable store: synchronous memory with per-entry valid bits so that
// entries never written read back as zero after reset
// ----------------------------------------------------------------------------
module isu_var_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [isu_pkg::VAR_AW-1:0]   rd_addr,
    output logic [isu_pkg::DATA_W-1:0]   rd_data,
    input  isu_pkg::var_wr_t             wr
);

    logic [isu_pkg::DATA_W-1:0]   mem [isu_pkg::NUM_VARS];
    logic [isu_pkg::NUM_VARS-1:0] valid_reg;
    logic [isu_pkg::DATA_W-1:0]   data_reg;
    logic                         hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
            hit_reg  <= valid_reg[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

FILE: rtl/integer_stack_expression_unit.sv
// ----------------------------------------------------------------------------
// integer_stack_expression_unit
// postfix evaluator for signed 64-bit expressions with c operators
// ----------------------------------------------------------------------------
// usage
// a request is taken on a rising edge with start high and busy low; cmd,
// value, var_index and no_eval are sampled there. every request gives one
// result: done is high for one cycle with top_value, depth and error_code.
// the receiver has no way to hold a result back, it must take it then.
// steps from the accepted request to done:
//   push, clear and combinational operators: two stack memory
//   reads, then the write back
//   multiply: three 32x32 partial products in the shared unit
//   divide and remainder: one quotient bit per cycle
// busy stays high until done; a new request may be given in the done cycle.
// the operand stack lives in a synchronous memory with separate read and write addresses, the top
// entry also held in registers; the variable store is a memory of its own.
// reset empties the stack, clears the error code and makes every variable
// read as zero. the error code keeps the first error until reset.
// ----------------------------------------------------------------------------
`include "integer_stack_expression_unit_defines.svh"

module integer_stack_expression_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [5:0]                              cmd,
    input  logic signed [isu_pkg::DATA_W-1:0]       value,
    input  logic [isu_pkg::VIDX_W-1:0]              var_index,
    input  logic                                    no_eval,
    output logic                                    done,
    output logic signed [isu_pkg::DATA_W-1:0]       top_value,
    output logic [isu_pkg::OUT_DEPTH_W-1:0]         depth,
    output logic [2:0]                              error_code
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_EXEC  = 4'b0100,
        S_WAIT  = 4'b1000
    } state_t;

    localparam int DW = isu_pkg::DATA_W;
    localparam int TW = isu_pkg::TAG_W;

    state_t                             state_reg;
    isu_pkg::cmd_t                      cmd_reg;
    logic [DW-1:0]                      value_reg;
    logic [isu_pkg::VIDX_W-1:0]         idx_reg;
    logic                               no_eval_reg;
    logic [isu_pkg::DEPTH_W-1:0]        stack_depth_reg;
    logic [DW-1:0]                      top_val_reg;
    logic [TW-1:0]                      top_tag_reg;
    logic [DW-1:0]                      opa_val_reg;
    logic [TW-1:0]                      opa_tag_reg;
    isu_pkg::err_t                      error_reg;
    logic                               done_reg;
    logic [DW-1:0]                      out_top_reg;
    logic [isu_pkg::OUT_DEPTH_W-1:0]    out_depth_reg;

    logic [isu_pkg::ENTRY_W-1:0]        stack_mem [isu_pkg::STACK_DEPTH];
    logic [isu_pkg::ENTRY_W-1:0]        ram_rdata_reg;
    logic                               ram_re;
    logic [isu_pkg::STK_AW-1:0]         ram_raddr;
    logic                               ram_we;
    logic [isu_pkg::STK_AW-1:0]         ram_waddr;

    logic                               accept;
    logic [isu_pkg::DEPTH_W-1:0]        d_m1;
    logic [isu_pkg::DEPTH_W-1:0]        d_m2;
    logic [isu_pkg::DEPTH_W-1:0]        d_m3;
    logic [DW-1:0]                      e3_val;
    logic [TW-1:0]                      e3_tag;
    logic [DW-1:0]                      var_rdata;

    isu_pkg::cmd_t                      base;
    logic                               short_ops;
    logic                               is_binary;
    logic                               dz;
    logic                               md_needed;
    logic [DW-1:0]                      alu_r;
    logic [DW-1:0]                      r;
    logic                               commit;
    isu_pkg::md_req_t                   md_req;
    isu_pkg::md_rsp_t                   md_rsp;
    isu_pkg::var_wr_t                   var_wr;

    logic [isu_pkg::DEPTH_W-1:0]        nd;
    logic [DW-1:0]                      nt;
    logic [TW-1:0]                      ntag;
    isu_pkg::err_t                      raise;
    logic                               push_en;
    logic [DW-1:0]                      push_val;
    logic [TW-1:0]                      push_tag;
    logic                               store_en;
    logic [TW-1:0]                      st_tag;
    logic [DW-1:0]                      st_val;
    logic                               st_ok;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign d_m1   = stack_depth_reg - isu_pkg::DEPTH_W'(1);
    assign d_m2   = stack_depth_reg - isu_pkg::DEPTH_W'(2);
    assign d_m3   = stack_depth_reg - isu_pkg::DEPTH_W'(3);
    assign e3_val = ram_rdata_reg[DW-1:0];
    assign e3_tag = ram_rdata_reg[isu_pkg::ENTRY_W-1:DW];

    // second entry is read at accept, third one in the fetch cycle
    assign ram_re    = accept || (state_reg == S_FETCH);
    assign ram_raddr = (state_reg == S_IDLE) ? d_m2[isu_pkg::STK_AW-1:0]
                                             : d_m3[isu_pkg::STK_AW-1:0];

    isu_var_store u_var_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (var_index[isu_pkg::VAR_AW-1:0]),
        .rd_data (var_rdata),
        .wr      (var_wr)
    );

    isu_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .opa   (opa_val_reg),
        .opb   (top_val_reg),
        .rsp   (md_rsp)
    );

    // combinational binary operators; a is the entry below the top, b the top
    always_comb
    begin
        base      = isu_pkg::base_op(cmd_reg);
        short_ops = (stack_depth_reg <
                     isu_pkg::DEPTH_W'(isu_pkg::operands_needed(cmd_reg)));
        is_binary = (base != isu_pkg::OP_ASSIGN) || (cmd_reg == isu_pkg::OP_ASSIGN);
        dz        = ((base == isu_pkg::OP_DIV) || (base == isu_pkg::OP_MOD))
                    && (top_val_reg == '0);
        md_needed = is_binary && !short_ops && !dz &&
                    ((base == isu_pkg::OP_MUL) || (base == isu_pkg::OP_DIV) ||
                     (base == isu_pkg::OP_MOD));
        case (base)
            isu_pkg::OP_AND:  alu_r = opa_val_reg & top_val_reg;
            isu_pkg::OP_XOR:  alu_r = opa_val_reg ^ top_val_reg;
            isu_pkg::OP_OR:   alu_r = opa_val_reg | top_val_reg;
            isu_pkg::OP_ADD:  alu_r = opa_val_reg + top_val_reg;
            isu_pkg::OP_SUB:  alu_r = opa_val_reg - top_val_reg;
            isu_pkg::OP_SHL:  alu_r = opa_val_reg << top_val_reg[5:0];
            isu_pkg::OP_SHR:  alu_r = $signed(opa_val_reg) >>> top_val_reg[5:0];
            isu_pkg::OP_LT:   alu_r = DW'($signed(opa_val_reg) < $signed(top_val_reg));
            isu_pkg::OP_LE:   alu_r = DW'($signed(opa_val_reg) <= $signed(top_val_reg));
            isu_pkg::OP_GT:   alu_r = DW'($signed(opa_val_reg) > $signed(top_val_reg));
            isu_pkg::OP_GE:   alu_r = DW'($signed(opa_val_reg) >= $signed(top_val_reg));
            isu_pkg::OP_EQ:   alu_r = DW'(opa_val_reg == top_val_reg);
            isu_pkg::OP_NE:   alu_r = DW'(opa_val_reg != top_val_reg);
            isu_pkg::OP_LAND: alu_r = DW'((opa_val_reg != '0) && (top_val_reg != '0));
            isu_pkg::OP_LOR:  alu_r = DW'((opa_val_reg != '0) || (top_val_reg != '0));
            isu_pkg::OP_LXOR: alu_r = DW'((opa_val_reg != '0) != (top_val_reg != '0));
            default:          alu_r = top_val_reg;
        endcase
    end

    always_comb
    begin
        md_req.start = (state_reg == S_EXEC) && md_needed;
        if (base == isu_pkg::OP_MUL)
        begin
            md_req.op = isu_pkg::MD_MUL;
        end
        else if (base == isu_pkg::OP_DIV)
        begin
            md_req.op = isu_pkg::MD_DIV;
        end
        else
        begin
            md_req.op = isu_pkg::MD_REM;
        end
        commit = ((state_reg == S_EXEC) && !md_needed) ||
                 ((state_reg == S_WAIT) && md_rsp.done);
        r      = (state_reg == S_WAIT) ? md_rsp.result : alu_r;
    end

    // next stack state for the request being finished
    always_comb
    begin
        nd       = stack_depth_reg;
        nt       = top_val_reg;
        ntag     = top_tag_reg;
        raise    = isu_pkg::ERR_NONE;
        push_en  = 1'b0;
        push_val = value_reg;
        push_tag = isu_pkg::NO_TAG;
        store_en = 1'b0;
        st_tag   = top_tag_reg;
        st_val   = top_val_reg + 1'b1;

        unique case (cmd_reg) inside
            isu_pkg::CMD_PUSH_LIT:
            begin
                push_en = 1'b1;
            end
            isu_pkg::CMD_PUSH_VAR:
            begin
                push_en = 1'b1;
                if (int'(idx_reg) < isu_pkg::NUM_VARS)
                begin
                    push_val = var_rdata;
                    push_tag = {1'b0, idx_reg};
                end
                else
                begin
                    push_val = '0;
                end
            end
            isu_pkg::CMD_CLEAR:
            begin
                nd = '0;
            end
            isu_pkg::OP_LNOT, isu_pkg::OP_BNOT, isu_pkg::OP_POSTINC,
            isu_pkg::OP_POSTDEC, isu_pkg::OP_PLUS, isu_pkg::OP_NEG,
            isu_pkg::OP_PREINC, isu_pkg::OP_PREDEC:
            begin
                if ((cmd_reg == isu_pkg::OP_POSTDEC) || (cmd_reg == isu_pkg::OP_PREDEC))
                begin
                    st_val = top_val_reg - 1'b1;
                end
                if (short_ops)
                begin
                    raise = isu_pkg::ERR_EMPTY;
                end
                else
                begin
                    case (cmd_reg) inside
                        isu_pkg::OP_LNOT:
                        begin
                            nt   = DW'(top_val_reg == '0);
                            ntag = isu_pkg::NO_TAG;
                        end
                        isu_pkg::OP_BNOT:
                        begin
                            nt   = ~top_val_reg;
                            ntag = isu_pkg::NO_TAG;
                        end
                        isu_pkg::OP_PLUS:
                        begin
                            ntag = isu_pkg::NO_TAG;
                        end
                        isu_pkg::OP_NEG:
                        begin
                            nt   = ~top_val_reg + 1'b1;
                            ntag = isu_pkg::NO_TAG;
                        end
                        isu_pkg::OP_POSTINC, isu_pkg::OP_POSTDEC:
                        begin
                            store_en = 1'b1;
                        end
                        default:
                        begin
                            store_en = 1'b1;
                            nt       = st_ok ? st_val : '0;
                        end
                    endcase
                end
            end
            isu_pkg::OP_COND:
            begin
                if (short_ops)
                begin
                    raise = isu_pkg::ERR_EMPTY;
                end
                else
                begin
                    nd   = d_m2;
                    nt   = (e3_val != '0) ? opa_val_reg : top_val_reg;
                    ntag = isu_pkg::NO_TAG;
                end
            end
            isu_pkg::OP_COMMA:
            begin
                if (short_ops)
                begin
                    raise = isu_pkg::ERR_EMPTY;
                end
                else
                begin
                    nd   = d_m1;
                    ntag = isu_pkg::NO_TAG;
                end
            end
            isu_pkg::OP_AND, isu_pkg::OP_XOR, isu_pkg::OP_OR, isu_pkg::OP_MUL,
            isu_pkg::OP_DIV, isu_pkg::OP_MOD, isu_pkg::OP_ADD, isu_pkg::OP_SUB,
            isu_pkg::OP_SHL, isu_pkg::OP_SHR, isu_pkg::OP_LT, isu_pkg::OP_LE,
            isu_pkg::OP_GT, isu_pkg::OP_GE, isu_pkg::OP_EQ, isu_pkg::OP_NE,
            isu_pkg::OP_LAND, isu_pkg::OP_LOR, isu_pkg::OP_LXOR:
            begin
                if (short_ops)
                begin
                    raise = isu_pkg::ERR_EMPTY;
                end
                else if (dz)
                begin
                    raise = isu_pkg::ERR_DIV_ZERO;
                    nd    = d_m2;
                    nt    = e3_val;
                    ntag  = e3_tag;
                end
                else
                begin
                    nd   = d_m1;
                    nt   = r;
                    ntag = isu_pkg::NO_TAG;
                end
            end
            isu_pkg::OP_ASSIGN, isu_pkg::OP_ADD_ASN, isu_pkg::OP_SUB_ASN,
            isu_pkg::OP_MUL_ASN, isu_pkg::OP_DIV_ASN, isu_pkg::OP_MOD_ASN,
            isu_pkg::OP_AND_ASN, isu_pkg::OP_XOR_ASN, isu_pkg::OP_OR_ASN,
            isu_pkg::OP_SHL_ASN, isu_pkg::OP_SHR_ASN, isu_pkg::OP_LAND_ASN,
            isu_pkg::OP_LOR_ASN, isu_pkg::OP_LXOR_ASN:
            begin
                st_tag = opa_tag_reg;
                st_val = r;
                if (short_ops)
                begin
                    raise = isu_pkg::ERR_EMPTY;
                end
                else if (dz)
                begin
                    raise = isu_pkg::ERR_DIV_ZERO;
                    nd    = d_m2;
                    nt    = e3_val;
                    ntag  = e3_tag;
                end
                else
                begin
                    store_en = 1'b1;
                    nd       = d_m1;
                    nt       = st_ok ? r : '0;
                    ntag     = opa_tag_reg;
                end
            end
            default:
            begin
                // the colon and unused codes leave everything alone
            end
        endcase

        if (store_en && !st_ok)
        begin
            raise = isu_pkg::ERR_LVALUE;
        end

        // a push onto a full stack replaces the top entry
        if (push_en)
        begin
            nt   = push_val;
            ntag = push_tag;
            if (int'(stack_depth_reg) >= isu_pkg::STACK_DEPTH)
            begin
                raise = isu_pkg::ERR_OVERFLOW;
            end
            else
            begin
                nd = stack_depth_reg + isu_pkg::DEPTH_W'(1);
            end
        end
    end

    assign st_ok = !st_tag[TW-1] && (int'(st_tag[isu_pkg::VIDX_W-1:0]) < isu_pkg::NUM_VARS);

    always_comb
    begin
        var_wr.en   = commit && store_en && st_ok && !no_eval_reg;
        var_wr.addr = st_tag[isu_pkg::VAR_AW-1:0];
        var_wr.data = st_val;
        ram_we      = commit && (nd != '0);
        ram_waddr   = isu_pkg::STK_AW'(nd - isu_pkg::DEPTH_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            stack_mem[ram_waddr] <= {ntag, nt};
        end
        if (ram_re)
        begin
            ram_rdata_reg <= stack_mem[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stack_depth_reg <= '0;
            error_reg       <= isu_pkg::ERR_NONE;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= commit;
            if (commit)
            begin
                stack_depth_reg <= nd;
                if (error_reg == isu_pkg::ERR_NONE)
                begin
                    error_reg <= raise;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= md_needed ? S_WAIT : S_IDLE;
                end
                S_WAIT:
                begin
                    if (md_rsp.done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= isu_pkg::cmd_t'(cmd);
            value_reg   <= value;
            idx_reg     <= var_index;
            no_eval_reg <= no_eval;
        end
        if (state_reg == S_FETCH)
        begin
            opa_val_reg <= ram_rdata_reg[DW-1:0];
            opa_tag_reg <= ram_rdata_reg[isu_pkg::ENTRY_W-1:DW];
        end
        if (commit)
        begin
            top_val_reg   <= nt;
            top_tag_reg   <= ntag;
            out_top_reg   <= (nd == '0) ? '0 : nt;
            out_depth_reg <= isu_pkg::OUT_DEPTH_W'(nd);
        end
    end

    assign done       = done_reg;
    assign top_value  = out_top_reg;
    assign depth      = out_depth_reg;
    assign error_code = error_reg;

    `ISU_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
    `ISU_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done, "request not held busy")
    `ISU_ASSERT_IMP(a_depth_range, 1'b1,
        stack_depth_reg <= isu_pkg::DEPTH_W'(isu_pkg::STACK_DEPTH), "stack depth overrun")
    `ISU_ASSERT_NXT(a_err_sticky, error_reg != isu_pkg::ERR_NONE,
        error_reg == $past(error_reg), "sticky error changed")
    `ISU_ASSERT_IMP(a_md_start, md_req.start, state_reg == S_EXEC, "muldiv started out of turn")

endmodule
